>>> rtl/lfpd_pkg.sv
package lfpd_pkg;

  // Field and datapath widths.
  localparam int DutyBits    = 10;
  localparam int PosBits     = 13;
  localparam int GainBits    = 16;
  localparam int LimitBits   = 8;
  localparam int CountBits   = 8;
  localparam int ErrBits     = PosBits + 1;
  localparam int SumBits     = 32;
  localparam int DeltaBits   = ErrBits + 1;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;
  localparam int FracBits    = 8;

  // Zero-extended gain times signed operand, then the three terms added.
  localparam int PropBits = GainBits + 1 + ErrBits;
  localparam int IntBits  = GainBits + 1 + SumBits;
  localparam int DiffBits = GainBits + 1 + DeltaBits;
  localparam int PidBits  = IntBits + 2;

  // Reset values of the configuration registers.
  localparam logic [GainBits-1:0]  KpReset     = GainBits'(256);
  localparam logic [PosBits-1:0]   TargetReset = PosBits'(3500);
  localparam logic [LimitBits-1:0] LimitReset  = LimitBits'(30);
  localparam logic [CountBits-1:0] CountMax    = '1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_KP     = 3'd0,
    CFG_KI     = 3'd1,
    CFG_KD     = 3'd2,
    CFG_BASE   = 3'd3,
    CFG_TARGET = 3'd4,
    CFG_LIMIT  = 3'd5
  } cfg_idx_e;

  // What the state tracker hands to the arithmetic pipeline for one word.
  typedef struct packed {
    logic signed [ErrBits-1:0]   err;
    logic signed [SumBits-1:0]   sum;
    logic signed [DeltaBits-1:0] delta;
    logic                        zero;
    logic                        running;
  } track_t;

endpackage

>>> rtl/lfpd_track.sv
module lfpd_track (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  lfpd_pkg::op_e                   op_i,
  input  logic [lfpd_pkg::PosBits-1:0]    position_i,
  input  logic                            right_mark_i,
  input  logic [lfpd_pkg::PosBits-1:0]    target_i,
  input  logic [lfpd_pkg::LimitBits-1:0]  limit_i,
  output lfpd_pkg::track_t                track_o
);
  import lfpd_pkg::*;

  logic                        run_q, run_d;
  logic signed [ErrBits-1:0]   prev_err_q, prev_err_d;
  logic signed [SumBits-1:0]   sum_q, sum_d;
  logic [CountBits-1:0]        count_q, count_d;
  logic                        prev_mark_q, prev_mark_d;

  logic signed [ErrBits-1:0]   err;
  logic signed [SumBits:0]     sum_wide;
  logic signed [SumBits-1:0]   sum_sat;
  logic signed [DeltaBits-1:0] delta;
  logic [CountBits-1:0]        count_inc;
  logic                        limit_hit;

  // Error against the setpoint and the saturating integral.
  assign err      = $signed({1'b0, position_i}) - $signed({1'b0, target_i});
  assign sum_wide = {sum_q[SumBits-1], sum_q} + (SumBits+1)'(err);
  always_comb begin
    if (sum_wide[SumBits] != sum_wide[SumBits-1]) begin
      sum_sat = sum_wide[SumBits] ? {1'b1, {(SumBits-1){1'b0}}}
                                  : {1'b0, {(SumBits-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SumBits-1:0];
    end
  end
  assign delta = DeltaBits'(err) - DeltaBits'(prev_err_q);

  // Marker rising edges count up and saturate.
  assign count_inc = (right_mark_i && !prev_mark_q && count_q != CountMax)
                     ? count_q + CountBits'(1) : count_q;
  assign limit_hit = count_inc >= CountBits'(limit_i);

  // Next state and the per-word control result.
  always_comb begin
    run_d             = run_q;
    prev_err_d        = prev_err_q;
    sum_d             = sum_q;
    count_d           = count_q;
    prev_mark_d       = prev_mark_q;
    track_o.err       = err;
    track_o.sum       = sum_sat;
    track_o.delta     = delta;
    track_o.zero      = 1'b1;
    track_o.running   = run_q;
    unique case (op_i)
      OP_START: begin
        run_d           = 1'b1;
        sum_d           = '0;
        prev_err_d      = '0;
        track_o.running = 1'b1;
      end
      OP_STOP: begin
        run_d           = 1'b0;
        track_o.running = 1'b0;
      end
      OP_TICK: begin
        if (run_q) begin
          sum_d       = sum_sat;
          prev_err_d  = err;
          prev_mark_d = right_mark_i;
          if (limit_hit) begin
            run_d           = 1'b0;
            count_d         = '0;
            track_o.running = 1'b0;
          end else begin
            count_d      = count_inc;
            track_o.zero = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State advances once per word leaving the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      prev_err_q  <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      prev_mark_q <= 1'b0;
    end else if (step_i) begin
      run_q       <= run_d;
      prev_err_q  <= prev_err_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      prev_mark_q <= prev_mark_d;
    end
  end

endmodule

>>> rtl/line_follow_pid_drive_unit.sv
// PID steering for a two-motor line follower.
// Input channel (in_valid_i / in_stall_o) carries one word per control event:
// op (tick, start, stop), the line position and the side marker level.
// Output channel (out_valid_o / out_stall_i) returns exactly one word per
// input word: the two motor duties and the run flag after that word.
// Configuration registers (gains, base duty, setpoint, marker limit) are
// written through cfg_valid_i / cfg_ready_o; cfg_ready_o is always high.
// Write them only while no words are in flight.
// One word is accepted every cycle while in_stall_o is low: the path is
// input register, state update, multiply stage, add/clamp stage and output
// register, each stage holding while the one after it is full.
// When the receiver stalls, words queue in the empty stages behind the
// output register, so up to four words are held before in_stall_o rises.
// Reset clears the run flag, integral, previous error, marker count and all
// pipeline valids, and loads the configuration reset values.
module line_follow_pid_drive_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        op_i,
  input  logic [lfpd_pkg::PosBits-1:0]      position_i,
  input  logic                              right_mark_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lfpd_pkg::DutyBits-1:0]     duty_a_o,
  output logic [lfpd_pkg::DutyBits-1:0]     duty_b_o,
  output logic                              running_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lfpd_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [lfpd_pkg::CfgDataBits-1:0]  cfg_data_i
);
  import lfpd_pkg::*;

  // Configuration registers.
  logic [GainBits-1:0]  kp_q, ki_q, kd_q;
  logic [DutyBits-1:0]  base_q;
  logic [PosBits-1:0]   target_q;
  logic [LimitBits-1:0] limit_q;

  // Pipeline stages.
  logic                 v0_q, v1_q, v2_q, v3_q;
  logic                 rdy0, rdy1, rdy2, rdy3;
  op_e                  op0_q;
  logic [PosBits-1:0]   pos0_q;
  logic                 mark0_q;
  track_t               trk;
  track_t               trk1_q;
  logic signed [PropBits-1:0] prop2_q;
  logic signed [IntBits-1:0]  int2_q;
  logic signed [DiffBits-1:0] diff2_q;
  logic                 zero2_q, run2_q;
  logic signed [PidBits-1:0]  pid;
  logic signed [PidBits-1:0]  base_scaled;
  logic [DutyBits-1:0]  duty_a_q, duty_b_q;
  logic                 running_q;

  // Clamp a Q.8 value to the duty range after flooring.
  function automatic logic [DutyBits-1:0] clamp_duty(input logic signed [PidBits-1:0] x);
    logic [DutyBits-1:0] res;
    if (x[PidBits-1]) begin
      res = '0;
    end else if (|x[PidBits-2:DutyBits+FracBits]) begin
      res = '1;
    end else begin
      res = x[DutyBits+FracBits-1:FracBits];
    end
    return res;
  endfunction

  // Configuration write port.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= KpReset;
      ki_q     <= '0;
      kd_q     <= '0;
      base_q   <= '0;
      target_q <= TargetReset;
      limit_q  <= LimitReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_KP:     kp_q     <= cfg_data_i;
        CFG_KI:     ki_q     <= cfg_data_i;
        CFG_KD:     kd_q     <= cfg_data_i;
        CFG_BASE:   base_q   <= cfg_data_i[DutyBits-1:0];
        CFG_TARGET: target_q <= cfg_data_i[PosBits-1:0];
        CFG_LIMIT:  limit_q  <= cfg_data_i[LimitBits-1:0];
        default: begin
        end
      endcase
    end
  end

  // Each stage takes a word when it is empty or its word moves on.
  assign rdy3       = !v3_q || !out_stall_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign rdy0       = !v0_q || rdy1;
  assign in_stall_o = !rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      op0_q   <= op_e'(op_i);
      pos0_q  <= position_i;
      mark0_q <= right_mark_i;
    end
  end

  // Run state, integral, previous error and marker count.
  lfpd_track u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (v0_q && rdy1),
    .op_i         (op0_q),
    .position_i   (pos0_q),
    .right_mark_i (mark0_q),
    .target_i     (target_q),
    .limit_i      (limit_q),
    .track_o      (trk)
  );

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      trk1_q <= trk;
    end
  end

  // Multiply stage: the three PID products.
  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      prop2_q <= $signed({1'b0, kp_q}) * trk1_q.err;
      int2_q  <= $signed({1'b0, ki_q}) * trk1_q.sum;
      diff2_q <= $signed({1'b0, kd_q}) * trk1_q.delta;
      zero2_q <= trk1_q.zero;
      run2_q  <= trk1_q.running;
    end
  end

  // Add and clamp stage into the output register.
  assign pid = PidBits'(prop2_q) + PidBits'(int2_q) + PidBits'(diff2_q);
  assign base_scaled = $signed({{(PidBits-DutyBits-FracBits){1'b0}}, base_q,
                                {FracBits{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      duty_a_q  <= zero2_q ? '0 : clamp_duty(base_scaled - pid);
      duty_b_q  <= zero2_q ? '0 : clamp_duty(base_scaled + pid);
      running_q <= run2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign duty_a_o    = duty_a_q;
  assign duty_b_o    = duty_b_q;
  assign running_o   = running_q;

endmodule
